### rtl/plti_pkg.sv
// ---------------------------------------------------------------------------
// plti_pkg: shared types and constants of the table interpolator
// Table geometry, fixed-point widths and the command and status structs
// between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package plti_pkg;

   localparam int MaxBins      = 256;
   localparam int AddrBits     = $clog2(MaxBins);
   localparam int CountBits    = AddrBits + 1;
   localparam int DataBits     = 32;
   localparam int FracBits     = 16;
   localparam int QuotBits     = FracBits + 1;
   localparam int DivBits      = DataBits + FracBits;
   localparam int StepBits     = $clog2(DivBits);

   // input command codes
   localparam logic CmdWrite = 1'b0;
   localparam logic CmdQuery = 1'b1;

   // result status codes
   localparam logic StatusOk    = 1'b0;
   localparam logic StatusEmpty = 1'b1;

   // table read address source
   typedef enum logic [1:0] {
      ADDR_FIRST = 2'b00,
      ADDR_LAST  = 2'b01,
      ADDR_SCAN  = 2'b10,
      ADDR_LOWER = 2'b11
   } addr_sel_type;

   // controller to datapath
   typedef struct packed {
      logic                 mem_write;
      logic                 mem_read;
      addr_sel_type         addr_sel;
      logic [AddrBits-1:0]  scan_index;
      logic                 capture_x;
      logic                 load_hi;
      logic                 load_lo;
      logic                 div_start;
      logic                 div_step;
      logic                 mul_lo;
      logic                 mul_hi;
      logic                 result_direct;
      logic                 result_interp;
      logic                 result_empty;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic x_le_data;    // query energy at or below energy read
      logic x_ge_data;    // query energy at or above energy read
      logic x_lt_data;    // query energy below energy read
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/plti_ram.sv
// ---------------------------------------------------------------------------
// plti_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module plti_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   output      logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // storage array with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/plti_datapath.sv
// ---------------------------------------------------------------------------
// plti_datapath: table storage and arithmetic of the interpolator
// Breakpoint RAMs, query compare, restoring divider for the fraction and
// a shared 32x17 multiplier for the weighted sum.
// ---------------------------------------------------------------------------
`default_nettype none

module plti_datapath (
   input  wire logic                              clock,
   input  wire plti_pkg::dp_cmd_type              cmd,
   input  wire logic [plti_pkg::AddrBits-1:0]     wr_index,
   input  wire logic [plti_pkg::AddrBits-1:0]     last_index,
   input  wire logic [plti_pkg::DataBits-1:0]     wr_energy,
   input  wire logic [plti_pkg::DataBits-1:0]     wr_opacity,
   input  wire logic [plti_pkg::DataBits-1:0]     query_energy,
   output      plti_pkg::dp_status_type           status,
   output      logic [plti_pkg::DataBits-1:0]     opacity_out,
   output      logic                              status_out
);

   localparam int DW = plti_pkg::DataBits;
   localparam int FB = plti_pkg::FracBits;
   localparam int QB = plti_pkg::QuotBits;
   localparam int VB = plti_pkg::DivBits;
   localparam int AW = plti_pkg::AddrBits;
   localparam logic [QB-1:0] One  = QB'(1) << FB;
   localparam logic [QB-1:0] Half = QB'(1) << (FB - 1);

   logic [AW-1:0]    addr;
   logic [DW-1:0]    e_rd;
   logic [DW-1:0]    o_rd;
   logic [DW-1:0]    x_ff;
   logic [DW-1:0]    e_hi_ff;
   logic [DW-1:0]    o_hi_ff;
   logic [DW-1:0]    seg_ff;
   logic [VB-1:0]    num_ff;
   logic [DW:0]      rem_ff;
   logic [QB-1:0]    quot_ff;
   logic             equal_ff;
   logic [DW+QB-1:0] prod_ff;
   logic [DW+QB:0]   acc_ff;
   logic [DW-1:0]    result_ff;
   logic             empty_ff;
   logic [DW:0]      rem_shift;
   logic [DW:0]      rem_sub;
   logic [QB-1:0]    frac;
   logic [DW-1:0]    mul_a;
   logic [QB-1:0]    mul_b;

   // table address select
   always_comb begin
      unique case (cmd.addr_sel)
         plti_pkg::ADDR_FIRST: addr = '0;
         plti_pkg::ADDR_LAST:  addr = last_index;
         plti_pkg::ADDR_SCAN:  addr = cmd.scan_index;
         plti_pkg::ADDR_LOWER: addr = cmd.scan_index - AW'(1);
         default:              addr = '0;
      endcase
      if (cmd.mem_write) begin
         addr = wr_index;
      end
   end

   plti_ram #(.Width(DW), .Depth(plti_pkg::MaxBins)) u_energy_ram (
      .clock   (clock),
      .wr_en   (cmd.mem_write),
      .addr    (addr),
      .wr_data (wr_energy),
      .rd_en   (cmd.mem_read),
      .rd_data (e_rd)
   );

   plti_ram #(.Width(DW), .Depth(plti_pkg::MaxBins)) u_opacity_ram (
      .clock   (clock),
      .wr_en   (cmd.mem_write),
      .addr    (addr),
      .wr_data (wr_opacity),
      .rd_en   (cmd.mem_read),
      .rd_data (o_rd)
   );

   // compare query against the energy just read
   assign status.x_le_data = (x_ff <= e_rd);
   assign status.x_ge_data = (x_ff >= e_rd);
   assign status.x_lt_data = (x_ff <  e_rd);

   // one restoring divide step
   assign rem_shift = {rem_ff[DW-1:0], num_ff[VB-1]};
   assign rem_sub   = rem_shift - {1'b0, seg_ff};

   // clamp fraction to one, half for a zero-width segment
   always_comb begin
      if (equal_ff) begin
         frac = Half;
      end else if (quot_ff > One) begin
         frac = One;
      end else begin
         frac = quot_ff;
      end
   end

   assign mul_a = cmd.mul_hi ? o_hi_ff : o_rd;
   assign mul_b = cmd.mul_hi ? frac : (One - frac);

   // arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.capture_x) begin
         x_ff <= query_energy;
      end
      if (cmd.load_hi) begin
         e_hi_ff <= e_rd;
         o_hi_ff <= o_rd;
      end
      if (cmd.load_lo) begin
         seg_ff   <= e_hi_ff - e_rd;
         num_ff   <= {x_ff - e_rd, FB'(0)};
         equal_ff <= (e_hi_ff == e_rd);
      end
      if (cmd.div_start) begin
         rem_ff  <= '0;
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         if (!rem_sub[DW]) begin
            rem_ff  <= rem_sub;
            quot_ff <= {quot_ff[QB-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift;
            quot_ff <= {quot_ff[QB-2:0], 1'b0};
         end
         num_ff <= {num_ff[VB-2:0], 1'b0};
      end
      if (cmd.mul_lo || cmd.mul_hi) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.mul_lo) begin
         acc_ff <= '0;
      end else if (cmd.mul_hi) begin
         acc_ff <= {1'b0, prod_ff};
      end
      if (cmd.result_direct) begin
         result_ff <= o_rd;
         empty_ff  <= plti_pkg::StatusOk;
      end else if (cmd.result_interp) begin
         result_ff <= DW'((acc_ff + {1'b0, prod_ff}) >> FB);
         empty_ff  <= plti_pkg::StatusOk;
      end else if (cmd.result_empty) begin
         result_ff <= '0;
         empty_ff  <= plti_pkg::StatusEmpty;
      end
   end

   assign opacity_out = result_ff;
   assign status_out  = empty_ff;

endmodule

`default_nettype wire

### rtl/plti_ctrl.sv
// ---------------------------------------------------------------------------
// plti_ctrl: sequencer of the interpolator
// Handshakes, bin count register, table scan and divide/multiply steps.
// ---------------------------------------------------------------------------
`default_nettype none

module plti_ctrl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic                               req_command,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [plti_pkg::CountBits-1:0]     csr_bins_in_use,
   output      logic [plti_pkg::AddrBits-1:0]      last_index,
   output      plti_pkg::dp_cmd_type               cmd,
   input  wire plti_pkg::dp_status_type            status
);

   localparam int AW = plti_pkg::AddrBits;
   localparam int CW = plti_pkg::CountBits;
   localparam int SB = plti_pkg::StepBits;
   localparam int DivSteps = plti_pkg::DivBits;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_FIRST  = 11'b00000000010,
      ST_FCHK   = 11'b00000000100,
      ST_LCHK   = 11'b00000001000,
      ST_SCAN   = 11'b00000010000,
      ST_SCHK   = 11'b00000100000,
      ST_LOWER  = 11'b00001000000,
      ST_DIV    = 11'b00010000000,
      ST_MLO    = 11'b00100000000,
      ST_MHI    = 11'b01000000000,
      ST_SUM    = 11'b10000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      bins_ff;
   logic [CW-1:0]      n_eff;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [SB-1:0]      step_ff, step_in;
   logic               rsp_valid_ff;
   logic               done;
   logic               req_fire;

   // bin count register; the count in use is clamped to table size
   always_ff @(posedge clock) begin
      if (reset) begin
         bins_ff <= '0;
      end else if (csr_valid) begin
         bins_ff <= csr_bins_in_use;
      end
   end

   assign csr_ready  = 1'b1;
   assign n_eff      = (bins_ff > CW'(plti_pkg::MaxBins)) ? CW'(plti_pkg::MaxBins) : bins_ff;
   assign last_index = AW'(n_eff - CW'(1));

   // no new word while a result word waits
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      done     = 1'b0;
      cmd      = '0;
      cmd.addr_sel   = plti_pkg::ADDR_FIRST;
      cmd.scan_index = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_command == plti_pkg::CmdWrite) begin
                  cmd.mem_write = 1'b1;
               end else if (n_eff == '0) begin
                  cmd.result_empty = 1'b1;
                  done = 1'b1;
               end else begin
                  cmd.capture_x = 1'b1;
                  state_in = ST_FIRST;
               end
            end
         end
         // read entry zero
         ST_FIRST: begin
            cmd.mem_read = 1'b1;
            cmd.addr_sel = plti_pkg::ADDR_FIRST;
            state_in = ST_FCHK;
         end
         // at or below first or single entry: first opacity, else read last
         ST_FCHK: begin
            if (n_eff == CW'(1) || status.x_le_data) begin
               cmd.result_direct = 1'b1;
               done = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.mem_read = 1'b1;
               cmd.addr_sel = plti_pkg::ADDR_LAST;
               state_in = ST_LCHK;
            end
         end
         ST_LCHK: begin
            if (status.x_ge_data) begin
               cmd.result_direct = 1'b1;
               done = 1'b1;
               state_in = ST_IDLE;
            end else begin
               idx_in = AW'(1);
               state_in = ST_SCAN;
            end
         end
         // linear scan for the upper breakpoint
         ST_SCAN: begin
            cmd.mem_read = 1'b1;
            cmd.addr_sel = plti_pkg::ADDR_SCAN;
            state_in = ST_SCHK;
         end
         ST_SCHK: begin
            if (status.x_lt_data || ({1'b0, idx_ff} == n_eff - CW'(1))) begin
               cmd.load_hi  = 1'b1;
               cmd.mem_read = 1'b1;
               cmd.addr_sel = plti_pkg::ADDR_LOWER;
               state_in = ST_LOWER;
            end else begin
               idx_in = idx_ff + AW'(1);
               cmd.mem_read = 1'b1;
               cmd.addr_sel = plti_pkg::ADDR_SCAN;
               cmd.scan_index = idx_ff + AW'(1);
            end
         end
         // lower entry arrives: set up divide
         ST_LOWER: begin
            cmd.load_lo   = 1'b1;
            cmd.div_start = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + SB'(1);
            if (step_ff == SB'(DivSteps - 1)) begin
               cmd.mem_read = 1'b1;
               cmd.addr_sel = plti_pkg::ADDR_LOWER;
               state_in = ST_MLO;
            end
         end
         ST_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.result_interp = 1'b1;
            done = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/piecewise_linear_table_interpolator.sv
// ---------------------------------------------------------------------------
// piecewise_linear_table_interpolator: breakpoint table with linear lookup
// Write words load (energy, opacity) breakpoints; query words return the
// interpolated opacity.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    command, index, energy, opacity, query
//   rsp      out  rsp_valid/rsp_ready    opacity_out, status
//   csr      in   csr_valid/csr_ready    bins_in_use
//
// A write goes straight to the table. A query on an empty table returns the
// empty status, a clamped query returns the first or last opacity, and an
// interpolated query runs the linear table scan and the 48-step restoring
// divider before the weighted sum.
// Reset is synchronous; the table is not cleared. The result register holds
// one word; no new word is taken while it waits.
// ---------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_table_interpolator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic [31:0] req_entry_energy,
   input  wire logic [31:0] req_entry_opacity,
   input  wire logic [31:0] req_query_energy,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [31:0] rsp_opacity_out,
   output      logic        rsp_status,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [8:0]  csr_bins_in_use
);

   plti_pkg::dp_cmd_type                cmd;
   plti_pkg::dp_status_type             status;
   logic [plti_pkg::AddrBits-1:0]       last_index;

   plti_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_bins_in_use (csr_bins_in_use),
      .last_index      (last_index),
      .cmd             (cmd),
      .status          (status)
   );

   plti_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .wr_index     (req_entry_index),
      .last_index   (last_index),
      .wr_energy    (req_entry_energy),
      .wr_opacity   (req_entry_opacity),
      .query_energy (req_query_energy),
      .status       (status),
      .opacity_out  (rsp_opacity_out),
      .status_out   (rsp_status)
   );

   // no item taken while a result waits
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("input taken while result pending");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_opacity_out))
      else $error("result dropped under stall");

   // write words produce no result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == plti_pkg::CmdWrite |=> !rsp_valid)
      else $error("result after write");

endmodule

`default_nettype wire

### test/piecewise_linear_table_interpolator_tb.sv
// ---------------------------------------------------------------------------
// piecewise_linear_table_interpolator_tb: self-checking bench of the table
// interpolator
// Loads breakpoint tables, sets the bin count through the csr port and sends
// queries. Each response word is checked against an in-bench interpolation
// predictor, under random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_table_interpolator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        command;
      logic [7:0]  entry_index;
      logic [31:0] entry_energy;
      logic [31:0] entry_opacity;
      logic [31:0] query_energy;
   } req_word_type;

   typedef struct packed {
      logic [31:0] opacity;
      logic        status;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = 1'b0;
   logic [7:0]  req_entry_index = '0;
   logic [31:0] req_entry_energy = '0;
   logic [31:0] req_entry_opacity = '0;
   logic [31:0] req_query_energy = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_opacity_out;
   logic        rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_bins_in_use = '0;
   logic        req_fired = 1'b0;

   // predictor state
   logic [31:0] energy_tbl [plti_pkg::MaxBins];
   logic [31:0] opacity_tbl [plti_pkg::MaxBins];
   logic [8:0]  bin_count;

   req_word_type pending_words [$];
   rsp_word_type expected_rsp [$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          mismatches = 0;
   int          sent_words = 0;
   bit          timed_out = 0;

   piecewise_linear_table_interpolator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_entry_index(req_entry_index),
      .req_entry_energy(req_entry_energy), .req_entry_opacity(req_entry_opacity),
      .req_query_energy(req_query_energy),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_opacity_out(rsp_opacity_out), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_bins_in_use(csr_bins_in_use)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // interpolated opacity for a query energy over the current table
   function automatic rsp_word_type interpolate_opacity(logic [31:0] x);
      rsp_word_type r;
      int          n;
      int          up;
      logic [31:0] e_lo, e_hi;
      logic [63:0] frac, acc, one;
      n = (bin_count > plti_pkg::MaxBins) ? plti_pkg::MaxBins : bin_count;
      one = 64'd1 << plti_pkg::FracBits;
      r.status = plti_pkg::StatusOk;
      if (n == 0) begin
         r.opacity = '0;
         r.status = plti_pkg::StatusEmpty;
      end else if (n == 1 || x <= energy_tbl[0]) begin
         r.opacity = opacity_tbl[0];
      end else if (x >= energy_tbl[n-1]) begin
         r.opacity = opacity_tbl[n-1];
      end else begin
         up = 1;
         while (up < n - 1 && !(x < energy_tbl[up])) up++;
         e_lo = energy_tbl[up-1];
         e_hi = energy_tbl[up];
         if (e_hi == e_lo) frac = one >> 1;
         else begin
            frac = ({32'd0, 32'(x - e_lo)} << plti_pkg::FracBits)
                   / {32'd0, 32'(e_hi - e_lo)};
            if (frac > one) frac = one;
         end
         acc = {32'd0, opacity_tbl[up-1]} * (one - frac)
             + {32'd0, opacity_tbl[up]} * frac;
         r.opacity = acc[plti_pkg::FracBits +: 32];
      end
      return r;
   endfunction

   // add one word to the driver queue
   task automatic queue_word(input req_word_type w);
      pending_words.insert(pending_words.size(), w);
      sent_words++;
   endtask

   // driver: one word at a time, changes on falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_fired) begin
            // hold
         end else if (pending_words.size() > 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_word_type w;
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_command <= w.command;
            req_entry_index <= w.entry_index;
            req_entry_energy <= w.entry_energy;
            req_entry_opacity <= w.entry_opacity;
            req_query_energy <= w.query_energy;
         end else begin
            req_valid <= 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // request monitor: update predictor on each accepted word
   always @(posedge clock) begin
      req_fired <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         if (req_command == plti_pkg::CmdWrite) begin
            energy_tbl[req_entry_index] <= req_entry_energy;
            opacity_tbl[req_entry_index] <= req_entry_opacity;
         end else begin
            expected_rsp.insert(expected_rsp.size(),
                                interpolate_opacity(req_query_energy));
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word: opacity %h status %b",
                        rsp_opacity_out, rsp_status);
         end else begin
            rsp_word_type e;
            e = expected_rsp.pop_front();
            if (e.opacity !== rsp_opacity_out || e.status !== rsp_status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected opacity %h status %b, got %h %b",
                           e.opacity, e.status, rsp_opacity_out, rsp_status);
            end
         end
      end
   end

   // csr write while idle
   task automatic write_bin_count(input logic [8:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_bins_in_use <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      bin_count = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until the block has drained all work
   task automatic drain;
      while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic req_word_type make_write(int idx, logic [31:0] e, logic [31:0] o);
      req_word_type w;
      w = '0;
      w.command = plti_pkg::CmdWrite;
      w.entry_index = idx[7:0];
      w.entry_energy = e;
      w.entry_opacity = o;
      w.query_energy = $urandom();
      return w;
   endfunction

   function automatic req_word_type make_query(logic [31:0] x);
      req_word_type w;
      w = '0;
      w.command = plti_pkg::CmdQuery;
      w.entry_index = 8'($urandom());
      w.entry_energy = $urandom();
      w.entry_opacity = $urandom();
      w.query_energy = x;
      return w;
   endfunction

   // random query energy biased toward the table span
   function automatic logic [31:0] pick_energy(int n);
      int k;
      k = $urandom_range(n - 1);
      case ($urandom_range(4))
         0: return $urandom();
         1: return energy_tbl[k];
         2: return energy_tbl[k] + $urandom_range(3) - 1;
         default: return (k + 1 < n) ?
            energy_tbl[k] + ((energy_tbl[k+1] - energy_tbl[k]) >> $urandom_range(8))
            : $urandom();
      endcase
   endfunction

   // load a fresh table of n entries, sorted or not
   task automatic load_table(int n, bit sorted);
      logic [31:0] e;
      e = sorted ? $urandom_range(32'h00ff_ffff) : 32'd0;
      for (int i = 0; i < n; i++) begin
         if (sorted) begin
            if ($urandom_range(9) == 0) e = e;
            else e = e + $urandom_range(32'h00ff_ffff);
            queue_word(make_write(i, e, $urandom()));
         end else begin
            queue_word(make_write(i, $urandom(), $urandom()));
         end
         energy_tbl[i] = 'x;
      end
   endtask

   initial begin
      int           phase;
      int           n;
      int           k;
      req_word_type w;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, then small handcrafted tables
      write_bin_count(9'd0);
      queue_word(make_query(32'h0));
      queue_word(make_query(32'hffff_ffff));
      queue_word(make_write(0, 32'h0100_0000, 32'hffff_ffff));
      queue_word(make_write(1, 32'h0100_0000, 32'h0000_0000));
      queue_word(make_write(2, 32'h0300_0000, 32'h0001_0000));
      queue_word(make_write(3, 32'hffff_ffff, 32'hffff_ffff));
      drain();
      write_bin_count(9'd1);
      queue_word(make_query(32'h0500_0000));
      drain();
      write_bin_count(9'd4);
      queue_word(make_query(32'h0));
      queue_word(make_query(32'h0100_0000));
      queue_word(make_query(32'h0200_0000));
      queue_word(make_query(32'h02ff_ffff));
      queue_word(make_query(32'hffff_fffe));
      queue_word(make_query(32'hffff_ffff));
      // unsorted table: energy dips below the first breakpoint
      queue_word(make_write(1, 32'h0080_0000, 32'h1234_5678));
      queue_word(make_query(32'h0200_0000));
      // writes above the bin count are harmless but exercised
      queue_word(make_write(255, 32'haaaa_aaaa, 32'h5555_5555));
      drain();

      // fill the whole table, then oversized count acts as full
      load_table(plti_pkg::MaxBins, 1);
      drain();
      write_bin_count(9'd256);
      queue_word(make_query(32'hffff_ffff));
      queue_word(make_query(energy_tbl[255] - 1));
      drain();
      write_bin_count(9'h1ff);
      queue_word(make_query(energy_tbl[254] + 1));
      drain();

      // random phases over different idling, table sizes and orderings
      phase = 0;
      while (sent_words < 1350) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         n = (phase % 7 == 6) ? $urandom_range(plti_pkg::MaxBins, 200)
                              : $urandom_range(16, 2);
         load_table(n, ($urandom_range(4) != 0));
         drain();
         write_bin_count(n[8:0]);
         for (int i = 0; i < 60; i++) begin
            if ($urandom_range(19) == 0) begin
               k = $urandom_range(n - 1);
               w = make_write(k, pick_energy(n), $urandom());
               queue_word(w);
            end else begin
               queue_word(make_query(pick_energy(n)));
            end
            // hold the sender once until everything is back
            if (phase == 2 && i == 30) drain();
         end
         drain();
         // shrinking the count keeps every index inside written entries
         write_bin_count(9'($urandom_range(n, 0)));
         for (int i = 0; i < 5; i++) queue_word(make_query($urandom()));
         drain();
         phase++;
      end

      if (mismatches == 0 && !timed_out)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #20ms;
      timed_out = 1;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
